// File: sv/spsu_pkg.sv
// ----------------------------------------------------------------------------
// spsu_pkg: shared types and constants
// Field widths, stream packing, item kinds and the search sequencer types.
// ----------------------------------------------------------------------------
package spsu_pkg;

  localparam int IDX_W     = 10;   // entry_index / found_index
  localparam int VAL_W     = 64;   // entry_value / query_key / found_value
  localparam int CNT_W     = 11;   // entry_count register
  localparam int S_TDATA_W = 144;  // 10 + 64 + 64 = 138, padded to bytes
  localparam int M_TDATA_W = 80;   // 10 + 64 = 74, padded to bytes

  localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

  // item kind, carried on s_tuser
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } srch_state_t;

  // top -> sequencer
  typedef struct packed {
    logic start;     // query word accepted this cycle
    logic out_free;  // output register can take a result this cycle
  } srch_ctl_t;

  // sequencer -> top
  typedef struct packed {
    logic idle;      // ready for a new word
    logic done;      // range closed, rd_data holds the final entry
  } srch_sts_t;

endpackage

// File: sv/spsu_table.sv
// ----------------------------------------------------------------------------
// spsu_table: sorted value table
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module spsu_table import spsu_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [VAL_W-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [VAL_W-1:0] rd_data
);

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: sv/spsu_search.sv
// ----------------------------------------------------------------------------
// spsu_search: halving search sequencer
// Keeps the live range [lo, hi] and drives the table read address; one
// probe compare per cycle with the single 64-bit comparator.
// ----------------------------------------------------------------------------
module spsu_search import spsu_pkg::*; #(
  parameter int AW = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  srch_ctl_t        ctl,
  input  logic [AW-1:0]    hi_init,
  input  logic [VAL_W-1:0] key_in,
  input  logic [VAL_W-1:0] rd_data,
  output logic [AW-1:0]    rd_addr,
  output logic [AW-1:0]    result_index,
  output srch_sts_t        sts
);

  srch_state_t      state, state_next;
  logic [AW-1:0]    lo, hi, lo_next, hi_next;
  logic [VAL_W-1:0] key;
  logic [AW-1:0]    mid;
  logic             less;

  // upper middle of [l, h], or l once the range has closed
  function automatic logic [AW-1:0] probe(input logic [AW-1:0] l,
                                          input logic [AW-1:0] h);
    logic [AW:0] s;
    s = {1'b0, l} + {1'b0, h} + {{AW{1'b0}}, 1'b1};
    return (l < h) ? s[AW:1] : l;
  endfunction

  assign mid  = probe(lo, hi);
  assign less = rd_data < key;

  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (state == ST_IDLE && ctl.start) begin
      lo_next = '0;
      hi_next = hi_init;
    end else if (state == ST_SEARCH && lo < hi) begin
      if (less) begin
        lo_next = mid;
      end else begin
        hi_next = mid - {{(AW-1){1'b0}}, 1'b1};
      end
    end
  end

  // address for the next probe goes out in the same cycle, data back next
  assign rd_addr      = probe(lo_next, hi_next);
  assign result_index = lo;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (ctl.start) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (lo == hi && ctl.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    sts.idle = 1'b0;
    sts.done = 1'b0;
    case (state)
      ST_IDLE:   sts.idle = 1'b1;
      ST_SEARCH: sts.done = (lo == hi);
      default:   sts.idle = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    lo <= lo_next;
    hi <= hi_next;
    if (state == ST_IDLE && ctl.start) begin
      key <= key_in;
    end
  end

endmodule

// File: sv/sorted_array_predecessor_search_unit.sv
// ----------------------------------------------------------------------------
// sorted_array_predecessor_search_unit: predecessor search over a sorted table
// Load words fill a table of DEPTH non-decreasing 64-bit values; query words
// return the largest index above zero whose value is below the key (else 0)
// and the value stored there.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake            payload
//   --------  ---  -------------------  ---------------------------------------
//   s_*       in   s_tvalid / s_tready  tuser: kind; tdata: index, value, key
//   m_*       out  m_tvalid / m_tready  tdata: found_index, found_value
//   cfg_*     in   cfg_valid/cfg_ready  cfg_data: entry_count
//
// Flow: a load word is written and the block stays ready. A query holds
//   s_tready low after acceptance through one table read and one 64-bit
//   compare per halving step on the single read port, plus the read of the
//   closing entry. The result word turns valid as s_tready comes back.
// s_tready is low while a query is searching; a result waiting in the output
//   register does not block loads, only the end of the next query.
// Reset (rst, synchronous): entry_count = 1024, no word pending. The table
//   itself is not cleared.
// ----------------------------------------------------------------------------
module sorted_array_predecessor_search_unit import spsu_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  // input words
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // entry_index[9:0], entry_value[73:10],
                                          // query_key[137:74], zero pad
  input  logic                 s_tuser,   // kind
  // result words
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // found_index[9:0], found_value[73:10],
                                          // zero pad
  // entry_count register
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CNT_W-1:0]     cfg_data
);

  localparam int AW = $clog2(DEPTH);

  // unpacked input fields
  logic [IDX_W-1:0] entry_index;
  logic [VAL_W-1:0] entry_value;
  logic [VAL_W-1:0] query_key;

  logic             in_acc;
  logic [CNT_W-1:0] entry_count;

  // table port
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;
  logic [VAL_W-1:0] rd_data;

  // search
  srch_ctl_t        ctl;
  srch_sts_t        sts;
  logic [AW-1:0]    hi_init;
  logic [AW-1:0]    result_index;

  // output register
  logic [IDX_W-1:0] out_index;
  logic [VAL_W-1:0] out_value;

  logic [31:0]      idx32;
  logic [31:0]      cnt32;
  logic [31:0]      live32;
  logic [31:0]      last32;
  logic [31:0]      res32;

  assign entry_index = s_tdata[IDX_W-1:0];
  assign entry_value = s_tdata[IDX_W+VAL_W-1:IDX_W];
  assign query_key   = s_tdata[IDX_W+2*VAL_W-1:IDX_W+VAL_W];

  assign s_tready = sts.idle;
  assign in_acc   = s_tvalid && s_tready;

  // config register, always ready; the live count is taken when a query starts
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= CNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      entry_count <= cfg_data;
    end
  end

  // loads beyond the table are dropped
  assign idx32   = 32'(entry_index);
  assign wr_en   = in_acc && (s_tuser == KIND_LOAD) && (idx32 < 32'(DEPTH));
  assign wr_addr = idx32[AW-1:0];

  // count of zero acts as one, count above DEPTH saturates
  always_comb begin
    cnt32 = 32'(entry_count);
    if (cnt32 == 32'd0) begin
      live32 = 32'd1;
    end else if (cnt32 > 32'(DEPTH)) begin
      live32 = 32'(DEPTH);
    end else begin
      live32 = cnt32;
    end
    last32  = live32 - 32'd1;
    hi_init = last32[AW-1:0];
  end

  assign ctl.start    = in_acc && (s_tuser == KIND_QUERY);
  assign ctl.out_free = !m_tvalid || m_tready;

  spsu_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (entry_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  spsu_search #(
    .AW (AW)
  ) u_search (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .hi_init      (hi_init),
    .key_in       (query_key),
    .rd_data      (rd_data),
    .rd_addr      (rd_addr),
    .result_index (result_index),
    .sts          (sts)
  );

  // result register: loads when the range closes and the slot is free
  assign res32 = 32'(result_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (sts.done && ctl.out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sts.done && ctl.out_free) begin
      out_index <= res32[IDX_W-1:0];
      out_value <= rd_data;
    end
  end

  assign m_tdata = {{(M_TDATA_W-IDX_W-VAL_W){1'b0}}, out_value, out_index};

endmodule

// File: sv/spsu_checker.sv
// ----------------------------------------------------------------------------
// spsu_checker: port-level checks
// Watches the top-level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module spsu_checker import spsu_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 s_tuser,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed or dropped while stalled");

  // a query occupies the sequencer
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == KIND_QUERY) |=> !s_tready)
    else $error("input still ready right after a query");

  // a load leaves the input ready
  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == KIND_LOAD) |=> s_tready)
    else $error("input not ready after a load");

  // no result can appear the cycle after a query starts from an empty output
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == KIND_QUERY) && !m_tvalid |=> !m_tvalid)
    else $error("result appeared too early");

endmodule

bind sorted_array_predecessor_search_unit spsu_checker u_spsu_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .s_tuser   (s_tuser),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata)
);
